[hw/rtl/dssc_pkg.sv]
// Package: transaction types, state encoding and defaults for the diagonal state-space scan core
package dssc_pkg;

    localparam int unsigned DEF_DIM = 256;

    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [15:0] gamma_val;
        logic signed [15:0] b_val;
        logic signed [15:0] x_val;
        logic signed [15:0] c_val;
        logic signed [31:0] init_value;
        logic               last_elem;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_state;
        logic signed [31:0] readout;
        logic               last_out;
    } t_out_item;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_ADD  = 6'b000100,
        ST_DOT  = 6'b001000,
        ST_ACC  = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

endpackage

[hw/rtl/diagonal_state_space_scan_core.sv]
// Top level: diagonal state-space scan core with state RAM read-modify-write and dot product
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one state element per
//   transaction. A step transaction updates element s at the internal element counter to
//   gamma*s + b*x (rounded, saturated Q15.16), writes it back and adds c*s' to the dot
//   product. A load transaction writes init_value at the counter position.
//   Output channel (o_out_valid / i_out_stall / o_out_data) gives one transaction per
//   input transaction; a step marked last_elem carries the rounded readout and clears the
//   accumulator, and any transaction marked last_elem ends the token (counter to zero).
//   Only one transaction is in flight: the input stalls until the item has walked the
//   six-state sequencer (RAM read, multiply, round and write back, dot multiply,
//   accumulate, finish); a load skips the dot multiply and accumulate states.
//   Reset clears the sequencer, counter, accumulator and output valid; the state RAM
//   holds nothing defined until each entry is loaded or stepped.
//   A stalled output holds its transaction; the next input is still accepted and worked
//   on, and its result waits in the finish state until the output register is free.
module diagonal_state_space_scan_core
    import dssc_pkg::*;
#(
    parameter int unsigned DIM = DEF_DIM
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int unsigned CntW = (DIM > 1) ? $clog2(DIM) : 1;
    localparam logic [CntW-1:0] CntMax = CntW'(DIM - 1);

    function automatic logic signed [31:0] round_sat(input logic signed [63:0] v);
        logic signed [52:0] r;
        logic               fits;
        r = {v[63], v[63:12]} + 53'(v[11]);
        fits = (&r[52:31]) | ~(|r[52:31]);
        if (fits) begin
            return r[31:0];
        end else if (r[52]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7fff_ffff;
        end
    endfunction

    logic [31:0] mem [DIM];

    t_state             r_state, n_state;
    t_in_item           r_item;
    logic [CntW-1:0]    r_cnt, n_cnt;
    logic signed [63:0] r_acc, n_acc;
    logic signed [31:0] r_rd_data;
    logic signed [47:0] r_prod_gs;
    logic signed [31:0] r_prod_bx;
    logic signed [31:0] r_ns;
    logic signed [47:0] r_prod_c;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic               in_acc;
    logic               out_free;
    logic signed [48:0] upd_sum;
    logic signed [31:0] upd_ns;
    logic signed [64:0] acc_sum;
    logic signed [63:0] acc_sat;

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign upd_sum = 49'(r_prod_gs) + {{13{r_prod_bx[31]}}, r_prod_bx, 4'b0000};
    assign upd_ns  = (r_item.command == CMD_LOAD) ? r_item.init_value
                                                   : round_sat(64'(upd_sum));

    assign acc_sum = {r_acc[63], r_acc} + 65'(r_prod_c);
    always_comb begin
        if (acc_sum[64] != acc_sum[63]) begin
            acc_sat = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            acc_sat = acc_sum[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[r_cnt];
        if (r_state == ST_ADD) begin
            mem[r_cnt] <= upd_ns;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: n_state = ST_ADD;
            ST_ADD: n_state = (r_item.command == CMD_LOAD) ? ST_FIN : ST_DOT;
            ST_DOT: n_state = ST_ACC;
            ST_ACC: begin
                n_acc   = acc_sat;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.new_state   = r_ns;
                    n_out.readout     = '0;
                    n_out.last_out    = 1'b0;
                    if (r_item.command == CMD_STEP && r_item.last_elem) begin
                        n_out.readout  = round_sat(r_acc);
                        n_out.last_out = 1'b1;
                        n_acc          = '0;
                    end
                    if (r_item.last_elem || r_cnt == CntMax) begin
                        n_cnt = '0;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_acc) begin
            r_item <= i_in_data;
        end
        if (r_state == ST_MUL) begin
            r_prod_gs <= 48'(r_item.gamma_val) * 48'(r_rd_data);
            r_prod_bx <= 32'(r_item.b_val) * 32'(r_item.x_val);
        end
        if (r_state == ST_ADD) begin
            r_ns <= upd_ns;
        end
        if (r_state == ST_DOT) begin
            r_prod_c <= 48'(r_item.c_val) * 48'(r_ns);
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hw/rtl/dssc_checker.sv]
// Checker: port-level assertions for the diagonal state-space scan core, with bind
module dssc_checker
    import dssc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction changed while stalled");

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> $stable(i_in_data))
        else $error("input transaction changed while stalled");

    // one item in flight: input stalls right after an acceptance
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while previous item in flight");

    a_readout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last_out |-> o_out_data.readout == 32'sd0)
        else $error("readout nonzero without last_out");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind diagonal_state_space_scan_core dssc_checker u_dssc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

[bench/tb_diagonal_state_space_scan_core.sv]
// Testbench for the diagonal state-space scan core: random and directed element streams vs. a fixed-point predictor
module tb_diagonal_state_space_scan_core;
    import dssc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DIM = DEF_DIM;
    localparam int PHASE_ITEMS = 150;
    localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint S32_MIN = -S32_MAX - 1;
    localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_MIN = -S64_MAX - 1;

    class scan_scoreboard;
        logic signed [31:0] elem [DIM];
        bit                 written [DIM];
        int unsigned        pos;
        longint             acc;
        t_out_item          pending [$];
        int                 errors;
        int                 steps;
        int                 loads;
        int                 readouts;
        int                 sat_readouts;

        function new();
            pos = 0;
            acc = 0;
            errors = 0;
            steps = 0;
            loads = 0;
            readouts = 0;
            sat_readouts = 0;
        endfunction

        function longint sat_add(longint a, longint p);
            longint s;
            s = a + p;
            if (a[63] == p[63] && s[63] != a[63]) begin
                return a[63] ? S64_MIN : S64_MAX;
            end
            return s;
        endfunction

        // Q.28 to Q.16, half rounds up, saturated to 32 bits
        function logic signed [31:0] round_q28(longint v);
            longint r;
            r = v >>> 12;
            r = r + longint'(v[11]);
            if (r > S32_MAX) begin
                return S32_MAX[31:0];
            end
            if (r < S32_MIN) begin
                return S32_MIN[31:0];
            end
            return r[31:0];
        endfunction

        function void note(t_in_item it);
            t_out_item exp;
            longint    sum;
            exp = '0;
            if (it.command == CMD_LOAD) begin
                exp.new_state = it.init_value;
                loads++;
            end else begin
                sum = longint'(it.gamma_val) * longint'(elem[pos])
                    + longint'(it.b_val) * longint'(it.x_val) * 16;
                exp.new_state = round_q28(sum);
                acc = sat_add(acc, longint'(it.c_val) * longint'(exp.new_state));
                if (it.last_elem) begin
                    exp.readout = round_q28(acc);
                    exp.last_out = 1'b1;
                    acc = 0;
                    readouts++;
                    if (exp.readout == S32_MAX[31:0] || exp.readout == S32_MIN[31:0]) begin
                        sat_readouts++;
                    end
                end
                steps++;
            end
            elem[pos] = exp.new_state;
            written[pos] = 1'b1;
            pos = (it.last_elem || pos == DIM - 1) ? 0 : pos + 1;
            pending.push_back(exp);
        endfunction

        function void check(t_out_item got);
            t_out_item exp;
            if (pending.size() == 0) begin
                $error("unexpected output transaction: new_state %0d readout %0d last_out %0b",
                       got.new_state, got.readout, got.last_out);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.new_state !== exp.new_state) begin
                $error("new_state: expected %0d, got %0d", exp.new_state, got.new_state);
                errors++;
            end
            if (got.readout !== exp.readout) begin
                $error("readout: expected %0d, got %0d", exp.readout, got.readout);
                errors++;
            end
            if (got.last_out !== exp.last_out) begin
                $error("last_out: expected %0b, got %0b", exp.last_out, got.last_out);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    scan_scoreboard sb = new();
    int tx_pct = 29;
    int rx_pct = 47;

    diagonal_state_space_scan_core #(.DIM(DIM)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #4ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < rx_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check(o_out_data);
        end
    end

    function automatic t_in_item mk(logic cmd, logic [15:0] g, logic [15:0] b, logic [15:0] x,
                                    logic [15:0] c, logic [31:0] init, logic last);
        t_in_item it;
        it.command = cmd;
        it.gamma_val = g;
        it.b_val = b;
        it.x_val = x;
        it.c_val = c;
        it.init_value = init;
        it.last_elem = last;
        return it;
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 63)) - 16'd32;
            4: return 16'($urandom_range(16'h0C00, 16'h1000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 1023)) - 32'd512;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_item(t_in_item it);
        while ($urandom_range(0, 99) < tx_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sb.note(it);
    endtask

    // a step is only issued where the element was already written
    task automatic run_token(int len);
        t_in_item it;
        logic     cmd;
        for (int k = 0; k < len; k++) begin
            if (!sb.written[sb.pos] || $urandom_range(0, 99) < 15) begin
                cmd = CMD_LOAD;
            end else begin
                cmd = CMD_STEP;
            end
            it = mk(cmd, pick16(), pick16(), pick16(), pick16(), pick32(), k == len - 1);
            push_item(it);
        end
    endtask

    task automatic run_directed();
        push_item(mk(CMD_LOAD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h7FFF_FFFF, 1'b0));
        push_item(mk(CMD_LOAD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h8000_0000, 1'b0));
        push_item(mk(CMD_LOAD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0001, 1'b0));
        // load closing a token: no readout, counter back to zero
        push_item(mk(CMD_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
        push_item(mk(CMD_STEP, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h0, 1'b0));
        push_item(mk(CMD_STEP, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 32'h0, 1'b0));
        push_item(mk(CMD_STEP, 16'h0800, 16'h8000, 16'h8000, 16'h8000, 32'h0, 1'b0));
        push_item(mk(CMD_STEP, 16'h0800, 16'h0000, 16'h0000, 16'h7FFF, 32'h0, 1'b1));
        push_item(mk(CMD_STEP, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 32'h0, 1'b0));
        push_item(mk(CMD_STEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b1));
        push_item(mk(CMD_STEP, 16'h1000, 16'h0000, 16'h0000, 16'h0001, 32'h0, 1'b1));
        push_item(mk(CMD_LOAD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0001_0000, 1'b1));
        push_item(mk(CMD_STEP, 16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFF, 32'h0, 1'b1));
        push_item(mk(CMD_LOAD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0001, 1'b0));
        push_item(mk(CMD_STEP, 16'h0000, 16'h0001, 16'h0080, 16'h8000, 32'h0, 1'b0));
        push_item(mk(CMD_STEP, 16'h0000, 16'h0001, 16'hFF80, 16'h8000, 32'h0, 1'b1));
    endtask

    initial begin
        int tx_sched [3];
        int rx_sched [3];
        int target;
        tx_sched = '{29, 47, 0};
        rx_sched = '{47, 29, 0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 3; ph++) begin
            tx_pct = tx_sched[ph];
            rx_pct = rx_sched[ph];
            if (ph == 0) begin
                run_directed();
            end
            if (ph == 2) begin
                run_token(DIM + $urandom_range(1, 16));
            end
            target = sb.steps + sb.loads + PHASE_ITEMS;
            while (sb.steps + sb.loads < target) begin
                run_token($urandom_range(1, 24));
            end
        end
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);
        $display("Covered %0d step and %0d load transactions, %0d tokens read out (%0d saturated),",
                 sb.steps, sb.loads, sb.readouts, sb.sat_readouts);
        $display("under both stall mixes and none, with a token longer than %0d elements.",
                 DIM);
        if (sb.errors == 0) begin
            $display("[diagonal_state_space_scan_core] OK");
        end else begin
            $display("[diagonal_state_space_scan_core] ERROR");
        end
        $finish;
    end

    initial begin
        #1ms;
        $display("[diagonal_state_space_scan_core] ERROR");
        $finish;
    end

endmodule

[files.f]
hw/rtl/dssc_pkg.sv
hw/rtl/diagonal_state_space_scan_core.sv
hw/rtl/dssc_checker.sv
bench/tb_diagonal_state_space_scan_core.sv
